/* rtl/core/swm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared constants and tables for the wipe mask pixel core
// wipe codes, register indexes, widths and box origin tables
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int unsigned MaxWidth  = 4096;
    localparam int unsigned MaxHeight = 4096;

    localparam int unsigned CodeW   = 5;
    localparam int unsigned SizeW   = 13;
    localparam int unsigned PixW    = 12;
    localparam int unsigned TimeW   = 40;
    localparam int unsigned MaskW   = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned NumW    = TimeW + SizeW;
    localparam int unsigned QW      = 13;
    localparam int unsigned EdgeW   = 17;
    localparam int unsigned HalfW   = 20;

    localparam logic [CfgIdxW-1:0] RegWipeCode = 2'd0;
    localparam logic [CfgIdxW-1:0] RegWidth    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegHeight   = 2'd2;
    localparam logic [CfgIdxW-1:0] RegDuration = 2'd3;

    localparam logic [CodeW-1:0] WipeBarH  = 5'd1;
    localparam logic [CodeW-1:0] WipeBarV  = 5'd2;
    localparam logic [CodeW-1:0] WipeBoxTl = 5'd3;
    localparam logic [CodeW-1:0] WipeBoxTr = 5'd4;
    localparam logic [CodeW-1:0] WipeBoxBr = 5'd5;
    localparam logic [CodeW-1:0] WipeBoxBl = 5'd6;
    localparam logic [CodeW-1:0] WipeQuadC = 5'd7;
    localparam logic [CodeW-1:0] WipeQuadM = 5'd8;
    localparam logic [CodeW-1:0] WipeBoxT  = 5'd23;
    localparam logic [CodeW-1:0] WipeBoxR  = 5'd24;
    localparam logic [CodeW-1:0] WipeBoxB  = 5'd25;
    localparam logic [CodeW-1:0] WipeBoxL  = 5'd26;

    localparam logic [MaskW-1:0] MaskOn  = 8'd255;
    localparam logic [MaskW-1:0] MaskOff = 8'd0;

    typedef struct packed {
        logic [2:0] a;
        logic [1:0] b;
        logic [2:0] c;
        logic [1:0] d;
    } geo_t;

    function automatic geo_t box_tab(input logic [2:0] row);
        geo_t g;
        case (row)
            3'd0:    g = '{3'd0, 2'd0, 3'd0, 2'd0};
            3'd1:    g = '{3'd2, 2'd2, 3'd0, 2'd0};
            3'd2:    g = '{3'd2, 2'd2, 3'd2, 2'd2};
            3'd3:    g = '{3'd0, 2'd0, 3'd2, 2'd2};
            3'd4:    g = '{3'd1, 2'd1, 3'd0, 2'd0};
            3'd5:    g = '{3'd2, 2'd2, 3'd1, 2'd1};
            3'd6:    g = '{3'd1, 2'd1, 3'd2, 2'd2};
            default: g = '{3'd0, 2'd0, 3'd1, 2'd1};
        endcase
        return g;
    endfunction

    function automatic geo_t quad_tab(input logic [2:0] row);
        geo_t g;
        case (row)
            3'd0:    g = '{3'd0, 2'd0, 3'd0, 2'd0};
            3'd1:    g = '{3'd1, 2'd1, 3'd1, 2'd1};
            3'd2:    g = '{3'd4, 2'd2, 3'd0, 2'd0};
            3'd3:    g = '{3'd3, 2'd1, 3'd1, 2'd1};
            3'd4:    g = '{3'd4, 2'd2, 3'd4, 2'd2};
            3'd5:    g = '{3'd1, 2'd1, 3'd3, 2'd1};
            3'd6:    g = '{3'd0, 2'd0, 3'd4, 2'd2};
            default: g = '{3'd3, 2'd1, 3'd3, 2'd1};
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/smpte_wipe_mask_pixel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle, stalls only while the output is held
// the split sizes come from a 13-stage restoring divider, one quotient bit
// per stage; aresetn clears valid bits and loads the register reset values
// ----------------------------------------------------------------------------
// smpte_wipe_mask_pixel: bar and box wipe transition mask
// per-pixel mask of 255 inside the painted bar or boxes, 0 outside
// ----------------------------------------------------------------------------
module smpte_wipe_mask_pixel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [39:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // pixel_x, pixel_y, time_position
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // mask_value
);

    localparam int unsigned NP = 18;
    localparam int unsigned ND = swm_pkg::QW;
    localparam int unsigned GS = NP - 2;

    logic [swm_pkg::CodeW-1:0] code_reg;
    logic [swm_pkg::SizeW-1:0] fw_reg, fh_reg;
    logic [swm_pkg::TimeW-1:0] dur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= swm_pkg::WipeBarH;
            fw_reg   <= 13'd640;
            fh_reg   <= 13'd480;
            dur_reg  <= 40'd1000000000;
        end else if (cfg_we) begin
            case (cfg_index)
                swm_pkg::RegWipeCode: code_reg <= cfg_data[swm_pkg::CodeW-1:0];
                swm_pkg::RegWidth:    fw_reg   <= cfg_data[swm_pkg::SizeW-1:0];
                swm_pkg::RegHeight:   fh_reg   <= cfg_data[swm_pkg::SizeW-1:0];
                default:              dur_reg  <= cfg_data;
            endcase
        end
    end

    logic [swm_pkg::SizeW-1:0] w, h;
    logic quad, single, bar_h, bar_v;

    assign w = (fw_reg > swm_pkg::SizeW'(swm_pkg::MaxWidth))
             ? swm_pkg::SizeW'(swm_pkg::MaxWidth) : fw_reg;
    assign h = (fh_reg > swm_pkg::SizeW'(swm_pkg::MaxHeight))
             ? swm_pkg::SizeW'(swm_pkg::MaxHeight) : fh_reg;
    assign quad   = (code_reg == swm_pkg::WipeQuadC) || (code_reg == swm_pkg::WipeQuadM);
    assign bar_h  = (code_reg == swm_pkg::WipeBarH);
    assign bar_v  = (code_reg == swm_pkg::WipeBarV);
    assign single = (code_reg >= swm_pkg::WipeBoxTl && code_reg <= swm_pkg::WipeBoxBl)
                 || (code_reg >= swm_pkg::WipeBoxT && code_reg <= swm_pkg::WipeBoxL);

    logic ce;
    logic [NP-1:0] vld_reg;

    assign ce       = !vld_reg[NP-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[NP-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NP-2:0], s_tvalid};
        end
    end

    logic [swm_pkg::PixW-1:0] px_reg [0:GS];
    logic [swm_pkg::PixW-1:0] py_reg [0:GS];

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg[0] <= s_tdata[11:0];
            py_reg[0] <= s_tdata[23:12];
            for (int i = 1; i <= GS; i++) begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
            end
        end
    end

    // clamp, partial products, numerator
    logic [swm_pkg::TimeW-1:0] pos_reg;
    logic [swm_pkg::HalfW+swm_pkg::SizeW-1:0] phx_reg, plx_reg, phy_reg, ply_reg;
    logic [swm_pkg::NumW-1:0] rx_reg [0:ND];
    logic [swm_pkg::NumW-1:0] ry_reg [0:ND];
    logic [swm_pkg::QW-1:0]   qx_reg [0:ND];
    logic [swm_pkg::QW-1:0]   qy_reg [0:ND];
    logic [swm_pkg::NumW-1:0] nx, ny;

    assign nx = ({phx_reg, 20'd0} + swm_pkg::NumW'(plx_reg)) >> quad;
    assign ny = ({phy_reg, 20'd0} + swm_pkg::NumW'(ply_reg)) >> quad;

    always_ff @(posedge aclk) begin
        if (ce) begin
            pos_reg <= (s_tdata[63:24] > dur_reg) ? dur_reg : s_tdata[63:24];
            phx_reg <= pos_reg[39:20] * w;
            plx_reg <= pos_reg[19:0] * w;
            phy_reg <= pos_reg[39:20] * h;
            ply_reg <= pos_reg[19:0] * h;
            rx_reg[0] <= nx;
            ry_reg[0] <= ny;
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar d = 0; d < ND; d++) begin : g_div
        localparam int unsigned K = ND - 1 - d;
        logic [swm_pkg::NumW-1:0] dsh;
        assign dsh = swm_pkg::NumW'(dur_reg) << K;
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (rx_reg[d] >= dsh) begin
                    rx_reg[d+1]    <= rx_reg[d] - dsh;
                    qx_reg[d+1]    <= qx_reg[d] | swm_pkg::QW'(1 << K);
                end else begin
                    rx_reg[d+1]    <= rx_reg[d];
                    qx_reg[d+1]    <= qx_reg[d];
                end
                if (ry_reg[d] >= dsh) begin
                    ry_reg[d+1]    <= ry_reg[d] - dsh;
                    qy_reg[d+1]    <= qy_reg[d] | swm_pkg::QW'(1 << K);
                end else begin
                    ry_reg[d+1]    <= ry_reg[d];
                    qy_reg[d+1]    <= qy_reg[d];
                end
            end
        end
    end

    // box edges
    logic [swm_pkg::QW-1:0] sx, sy;
    assign sx = (dur_reg == '0) ? (w >> quad) : qx_reg[ND];
    assign sy = (dur_reg == '0) ? (h >> quad) : qy_reg[ND];

    function automatic logic signed [swm_pkg::EdgeW-1:0] edge0(
        input logic [2:0] a, input logic [1:0] b,
        input logic [swm_pkg::SizeW-1:0] sz, input logic [swm_pkg::QW-1:0] s,
        input logic q);
        logic [swm_pkg::EdgeW-1:0] az, bs;
        az = swm_pkg::EdgeW'(a) * swm_pkg::EdgeW'(sz);
        bs = swm_pkg::EdgeW'(b) * swm_pkg::EdgeW'(s);
        az = q ? (az >> 2) : (az >> 1);
        bs = bs >> 1;
        return $signed(az - bs);
    endfunction

    logic signed [swm_pkg::EdgeW-1:0] x0_reg [0:3];
    logic signed [swm_pkg::EdgeW-1:0] x1_reg [0:3];
    logic signed [swm_pkg::EdgeW-1:0] y0_reg [0:3];
    logic signed [swm_pkg::EdgeW-1:0] y1_reg [0:3];
    logic [3:0] en_reg;
    logic       inf_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            inf_reg <= (swm_pkg::SizeW'(px_reg[GS-1]) < w)
                    && (swm_pkg::SizeW'(py_reg[GS-1]) < h);
            for (int k = 0; k < 4; k++) begin
                swm_pkg::geo_t g;
                logic signed [swm_pkg::EdgeW-1:0] ex, ey;
                g = quad ? swm_pkg::quad_tab(3'(code_reg - swm_pkg::WipeQuadC) + 3'(2 * k))
                         : swm_pkg::box_tab(3'(code_reg[3:0] - 4'd3));
                ex = edge0(g.a, g.b, w, sx, quad);
                ey = edge0(g.c, g.d, h, sy, quad);
                if (bar_h || bar_v) begin
                    x0_reg[k] <= '0;
                    y0_reg[k] <= '0;
                    x1_reg[k] <= bar_h ? $signed(swm_pkg::EdgeW'(sx))
                                       : $signed(swm_pkg::EdgeW'(w));
                    y1_reg[k] <= bar_v ? $signed(swm_pkg::EdgeW'(sy))
                                       : $signed(swm_pkg::EdgeW'(h));
                end else begin
                    x0_reg[k] <= ex;
                    y0_reg[k] <= ey;
                    x1_reg[k] <= ex + $signed(swm_pkg::EdgeW'(sx));
                    y1_reg[k] <= ey + $signed(swm_pkg::EdgeW'(sy));
                end
            end
            en_reg <= quad ? 4'b1111 : ((single || bar_h || bar_v) ? 4'b0001 : 4'b0000);
        end
    end

    // inside test and output register
    logic signed [swm_pkg::EdgeW-1:0] pxs, pys;
    logic hit;
    logic [swm_pkg::MaskW-1:0] mask_reg;

    assign pxs = $signed(swm_pkg::EdgeW'(px_reg[GS]));
    assign pys = $signed(swm_pkg::EdgeW'(py_reg[GS]));

    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (en_reg[k] && pxs >= x0_reg[k] && pxs < x1_reg[k]
                && pys >= y0_reg[k] && pys < y1_reg[k]) begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mask_reg <= (inf_reg && hit) ? swm_pkg::MaskOn : swm_pkg::MaskOff;
        end
    end

    assign m_tdata = mask_reg;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: wipe mask pixel testbench
// drives pixel transactions through the stream ports, predicts each mask
// value from the configured wipe and compares results in order
// ----------------------------------------------------------------------------

class mask_scoreboard;
    logic [4:0]  code;
    logic [12:0] fw;
    logic [12:0] fh;
    logic [39:0] dur;
    logic [7:0]  pending_masks[$];
    int          errors;

    function new();
        code = swm_pkg::WipeBarH;
        fw = 13'd640;
        fh = 13'd480;
        dur = 40'd1000000000;
        errors = 0;
    endfunction

    function automatic longint split_size(logic [39:0] pos, longint sz, longint dv);
        logic [127:0] num;
        if (dur == 0) return sz / dv;
        num = 128'(pos) * 128'(sz);
        return longint'((num / 128'(dv)) / 128'(dur));
    endfunction

    function automatic bit in_box(longint px, longint py, longint x0, longint y0,
                                  longint w, longint h);
        return px >= x0 && px < x0 + w && py >= y0 && py < y0 + h;
    endfunction

    function automatic logic [7:0] mask_of(logic [11:0] x, logic [11:0] y,
                                           logic [39:0] t);
        longint w, h, px, py, sx, sy, x0, y0;
        logic [39:0] pos;
        swm_pkg::geo_t g;
        bit hit;
        w = (fw > swm_pkg::MaxWidth) ? swm_pkg::MaxWidth : fw;
        h = (fh > swm_pkg::MaxHeight) ? swm_pkg::MaxHeight : fh;
        px = x;
        py = y;
        pos = (t > dur) ? dur : t;
        hit = 0;
        if (px < w && py < h) begin
            if (code == swm_pkg::WipeBarH) begin
                hit = px < split_size(pos, w, 1);
            end else if (code == swm_pkg::WipeBarV) begin
                hit = py < split_size(pos, h, 1);
            end else if ((code >= swm_pkg::WipeBoxTl && code <= swm_pkg::WipeBoxBl) ||
                         (code >= swm_pkg::WipeBoxT && code <= swm_pkg::WipeBoxL)) begin
                case (code)
                    swm_pkg::WipeBoxTl: g = '{3'd0, 2'd0, 3'd0, 2'd0};
                    swm_pkg::WipeBoxTr: g = '{3'd2, 2'd2, 3'd0, 2'd0};
                    swm_pkg::WipeBoxBr: g = '{3'd2, 2'd2, 3'd2, 2'd2};
                    swm_pkg::WipeBoxBl: g = '{3'd0, 2'd0, 3'd2, 2'd2};
                    swm_pkg::WipeBoxT:  g = '{3'd1, 2'd1, 3'd0, 2'd0};
                    swm_pkg::WipeBoxR:  g = '{3'd2, 2'd2, 3'd1, 2'd1};
                    swm_pkg::WipeBoxB:  g = '{3'd1, 2'd1, 3'd2, 2'd2};
                    default:            g = '{3'd0, 2'd0, 3'd1, 2'd1};
                endcase
                sx = split_size(pos, w, 1);
                sy = split_size(pos, h, 1);
                x0 = (g.a * w) / 2 - (g.b * sx) / 2;
                y0 = (g.c * h) / 2 - (g.d * sy) / 2;
                hit = in_box(px, py, x0, y0, sx, sy);
            end else if (code == swm_pkg::WipeQuadC || code == swm_pkg::WipeQuadM) begin
                sx = split_size(pos, w, 2);
                sy = split_size(pos, h, 2);
                for (int k = 0; k < 4; k++) begin
                    // corner boxes for the corner wipe, centred boxes otherwise
                    case ({code == swm_pkg::WipeQuadM, 2'(k)})
                        3'd0: g = '{3'd0, 2'd0, 3'd0, 2'd0};
                        3'd1: g = '{3'd4, 2'd2, 3'd0, 2'd0};
                        3'd2: g = '{3'd4, 2'd2, 3'd4, 2'd2};
                        3'd3: g = '{3'd0, 2'd0, 3'd4, 2'd2};
                        3'd4: g = '{3'd1, 2'd1, 3'd1, 2'd1};
                        3'd5: g = '{3'd3, 2'd1, 3'd1, 2'd1};
                        3'd6: g = '{3'd1, 2'd1, 3'd3, 2'd1};
                        default: g = '{3'd3, 2'd1, 3'd3, 2'd1};
                    endcase
                    x0 = (g.a * w) / 4 - (g.b * sx) / 2;
                    y0 = (g.c * h) / 4 - (g.d * sy) / 2;
                    if (in_box(px, py, x0, y0, sx, sy)) hit = 1;
                end
            end
        end
        return hit ? swm_pkg::MaskOn : swm_pkg::MaskOff;
    endfunction

    function void set_reg(logic [1:0] idx, logic [39:0] v);
        case (idx)
            swm_pkg::RegWipeCode: code = v[4:0];
            swm_pkg::RegWidth:    fw = v[12:0];
            swm_pkg::RegHeight:   fh = v[12:0];
            default:              dur = v;
        endcase
    endfunction

    function void note_pixel(logic [63:0] d);
        pending_masks.push_back(mask_of(d[11:0], d[23:12], d[63:24]));
    endfunction

    function void check_mask(logic [7:0] got);
        logic [7:0] exp_v;
        if (pending_masks.size() == 0) begin
            $display("%0t: unexpected mask transaction, actual %0d", $time, got);
            errors++;
            return;
        end
        exp_v = pending_masks.pop_front();
        if (got !== exp_v) begin
            $display("%0t: mask_value mismatch, expected %0d, actual %0d",
                     $time, exp_v, got);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [39:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;

    mask_scoreboard sb = new();
    int src_idle_pct = 10;
    int snk_idle_pct = 60;
    int hold_cycles = 0;

    smpte_wipe_mask_pixel uut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_mask(m_tdata);
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [39:0] v);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [39:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {t, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel({t, y, x});
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(negedge aclk);
        while (sb.pending_masks.size() != 0) @(negedge aclk);
        repeat (24) @(negedge aclk);
    endtask

    task automatic setup(logic [4:0] c, logic [12:0] w, logic [12:0] h, logic [39:0] d);
        drain();
        write_reg(swm_pkg::RegWipeCode, 40'(c));
        write_reg(swm_pkg::RegWidth, 40'(w));
        write_reg(swm_pkg::RegHeight, 40'(h));
        write_reg(swm_pkg::RegDuration, d);
    endtask

    function automatic logic [4:0] pick_code();
        case ($urandom_range(9))
            0: return swm_pkg::WipeBarH;
            1: return swm_pkg::WipeBarV;
            2: return 5'($urandom_range(3, 6));
            3: return 5'($urandom_range(23, 26));
            4, 5: return swm_pkg::WipeQuadC;
            6, 7: return swm_pkg::WipeQuadM;
            8: return 5'($urandom_range(9, 22));
            default: return $urandom_range(1) ? 5'd0 : 5'($urandom_range(27, 31));
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [12:0] w, h;
        logic [39:0] d, t;
        int sel;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                sel = $urandom_range(9);
                w = sel == 0 ? 13'($urandom_range(4097, 8191)) :
                    sel == 1 ? 13'($urandom_range(1, 4)) : 13'($urandom_range(1, 64));
                h = sel == 2 ? 13'($urandom_range(4097, 8191)) :
                    sel == 3 ? 13'd0 : 13'($urandom_range(1, 64));
                sel = $urandom_range(3);
                d = sel == 0 ? 40'($urandom_range(0, 100)) :
                    sel == 1 ? {$urandom(), 8'($urandom())} :
                    sel == 2 ? 40'hFF_FFFF_FFFF : 40'($urandom_range(1, 1000000));
                setup(pick_code(), w, h, d);
            end
            t = $urandom_range(9) == 0 ? {$urandom(), 8'($urandom())} :
                40'((64'(d) * $urandom_range(0, 1100)) / 1000);
            if ($urandom_range(19) == 0)
                send_pixel(12'($urandom()), 12'($urandom()), t);
            else
                send_pixel(12'($urandom_range(0, w + 2)), 12'($urandom_range(0, h + 2)), t);
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // defaults after reset
        send_pixel(12'd0, 12'd0, 40'd500000000);
        send_pixel(12'd319, 12'd479, 40'd500000000);
        send_pixel(12'd320, 12'd0, 40'd500000000);
        send_pixel(12'd639, 12'd0, 40'hFF_FFFF_FFFF);
        send_pixel(12'd640, 12'd0, 40'hFF_FFFF_FFFF);
        send_pixel(12'hFFF, 12'hFFF, 40'd0);
        for (int c = 1; c <= 8; c++) begin
            setup(5'(c), 13'd16, 13'd16, 40'd4);
            send_pixel(12'd7, 12'd7, 40'd2);
            send_pixel(12'd3, 12'd12, 40'd3);
        end
        for (int c = 23; c <= 26; c++) begin
            setup(5'(c), 13'd16, 13'd16, 40'd8);
            send_pixel(12'd8, 12'd8, 40'd4);
        end
        setup(swm_pkg::WipeQuadM, 13'h1FFF, 13'h1FFF, 40'd0);
        send_pixel(12'd1024, 12'd1024, 40'd5);
        setup(5'd31, 13'd16, 13'd16, 40'd1);
        send_pixel(12'd0, 12'd0, 40'd1);

        // long output hold-off while pixels keep arriving
        setup(swm_pkg::WipeBarH, 13'd32, 13'd32, 40'd32);
        hold_cycles = 300;
        for (int i = 0; i < 80; i++) send_pixel(12'(i % 32), 12'd0, 40'(i % 40));
        drain();

        src_idle_pct = 10;
        snk_idle_pct = 60;
        random_phase(560);
        src_idle_pct = 60;
        snk_idle_pct = 10;
        random_phase(560);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(420);
        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

/* files.f */
rtl/core/swm_pkg.sv
rtl/core/smpte_wipe_mask_pixel.sv
dv/tb_top.sv
